// ----- rtl/core/adjseq_pkg.sv -----
// ----------------------------------------------------------------------------
// adjseq_pkg
// Shared constants, types and the modular adder for the adjacent step
// sequence counter.
// ----------------------------------------------------------------------------
package adjseq_pkg;

  // Number of candidate values, one cell each.
  localparam int MAX_VALUE = 128;
  localparam int IDX_W     = (MAX_VALUE > 1) ? $clog2(MAX_VALUE) : 1;
  localparam int CNT_W     = $clog2(MAX_VALUE + 1);
  // Width used to compare values, counts and the limit register.
  localparam int M_W       = (CNT_W > 8) ? CNT_W : 8;

  localparam int WAY_W     = 30;
  localparam int VAL_W     = 8;

  localparam logic [WAY_W-1:0] MODULUS       = WAY_W'(1000000007);
  localparam logic [VAL_W-1:0] MAX_VAL_RESET = VAL_W'(100);

  // Operation applied by every cell in one cycle.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SEED,
    OP_STEP,
    OP_ROTATE
  } cell_op_e;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_SUM
  } state_e;

  // Control broadcast along the chain.
  typedef struct packed {
    cell_op_e         op;
    logic [VAL_W-1:0] fixed;
    logic [M_W-1:0]   lim;
  } cell_ctrl_t;

  // Sum of two residues, reduced once (both inputs are below the modulus).
  function automatic logic [WAY_W-1:0] add_mod(input logic [WAY_W-1:0] a,
                                               input logic [WAY_W-1:0] b);
    logic [WAY_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MODULUS}) begin
      s = s - {1'b0, MODULUS};
    end
    return s[WAY_W-1:0];
  endfunction

endpackage

// ----- rtl/core/adjseq_cell.sv -----
// ----------------------------------------------------------------------------
// adjseq_cell
// One cell of the chain: holds the count of prefixes ending in its value,
// updates from its neighbors, and shifts its count down during a sum pass.
// ----------------------------------------------------------------------------
module adjseq_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  adjseq_pkg::cell_ctrl_t    ctrl_i,
  input  logic [adjseq_pkg::IDX_W-1:0] idx_i,
  input  logic [adjseq_pkg::WAY_W-1:0] left_i,
  input  logic [adjseq_pkg::WAY_W-1:0] right_i,
  output logic [adjseq_pkg::WAY_W-1:0] count_o
);
  import adjseq_pkg::*;

  logic [WAY_W-1:0] count_q, count_d;
  logic [M_W-1:0]   val;
  logic             in_range, right_ok, left_ok, fixed_ok, keep;
  logic [WAY_W-1:0] left_term, right_term, step_sum;

  // The cell stands for value idx+1.
  assign val      = M_W'(idx_i) + M_W'(1);
  assign in_range = M_W'(idx_i) < ctrl_i.lim;
  assign right_ok = val < ctrl_i.lim;
  assign left_ok  = (idx_i != '0);
  assign fixed_ok = (ctrl_i.fixed == '0) || (M_W'(ctrl_i.fixed) == val);
  assign keep     = in_range && fixed_ok;

  // Neighbor sum, reduced after each addition.
  assign left_term  = left_ok  ? left_i  : '0;
  assign right_term = right_ok ? right_i : '0;
  assign step_sum   = add_mod(add_mod(count_q, left_term), right_term);

  // Next count.
  always_comb begin
    count_d = count_q;
    case (ctrl_i.op)
      OP_SEED:   count_d = keep ? WAY_W'(1) : '0;
      OP_STEP:   count_d = keep ? step_sum : '0;
      OP_ROTATE: count_d = right_i;
      OP_HOLD:   count_d = count_q;
      default:   count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

// ----- rtl/core/adjacent_step_sequence_count_core.sv -----
// ----------------------------------------------------------------------------
// adjacent_step_sequence_count_core
// Counts arrays whose neighboring entries differ by at most one, modulo
// 1e9+7, with one cell per candidate value in a ring.
// ----------------------------------------------------------------------------
// Operation: a position that is not last is absorbed while the block stays
//   idle; a last position updates the cells, then the counts rotate once
//   around the cell ring past the accumulator, and the sum is registered.
// Throughput: one beat per cycle while no last position arrives; after a last
//   position, input ready stays low during the rotation, and longer while the
//   previous result still waits at the end of the pass.
// Reset: all counts clear to zero and max_value returns to 100.
// ----------------------------------------------------------------------------
module adjacent_step_sequence_count_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: max_value.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // Input positions.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] fixed_value
  input  logic [0:0]  s_axis_tuser,   // [0] first_pos
  input  logic        s_axis_tlast,   // last_pos
  // Results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [29:0] way_count, [31:30] zero
);
  import adjseq_pkg::*;

  state_e           state_q, state_d;
  logic [VAL_W-1:0] max_val_q;
  logic [M_W-1:0]   m_ext, lim;
  logic [IDX_W-1:0] rot_cnt_q, rot_cnt_d;
  logic [WAY_W-1:0] acc_q, acc_d, term, acc_sum;
  logic             out_valid_q;
  logic [WAY_W-1:0] out_data_q;
  logic             in_beat, last_rot, advance, finish;
  cell_ctrl_t       ctrl;
  logic [WAY_W-1:0] counts [MAX_VALUE];

  // Configuration register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_val_q <= MAX_VAL_RESET;
    end else if (cfg_valid_i) begin
      max_val_q <= cfg_data_i;
    end
  end

  // Effective limit, saturated at the number of cells.
  assign m_ext = M_W'(max_val_q);
  assign lim   = (m_ext > M_W'(MAX_VALUE)) ? M_W'(MAX_VALUE) : m_ext;

  // Sum pass bookkeeping.
  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign last_rot = (rot_cnt_q == IDX_W'(MAX_VALUE - 1));
  assign advance  = !(last_rot && out_valid_q && !m_axis_tready);
  assign finish   = (state_q == ST_SUM) && last_rot && advance;
  assign term     = (M_W'(rot_cnt_q) < lim) ? counts[0] : '0;
  assign acc_sum  = add_mod(acc_q, term);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_beat && s_axis_tlast) state_d = ST_SUM;
      ST_SUM:  if (finish) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs and datapath next values.
  always_comb begin
    s_axis_tready = 1'b0;
    ctrl.op       = OP_HOLD;
    ctrl.fixed    = s_axis_tdata;
    ctrl.lim      = lim;
    rot_cnt_d     = rot_cnt_q;
    acc_d         = acc_q;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        rot_cnt_d     = '0;
        acc_d         = '0;
        if (in_beat) begin
          ctrl.op = s_axis_tuser[0] ? OP_SEED : OP_STEP;
        end
      end
      ST_SUM: begin
        if (advance) begin
          ctrl.op   = OP_ROTATE;
          rot_cnt_d = rot_cnt_q + IDX_W'(1);
          acc_d     = acc_sum;
        end
      end
      default: ctrl.op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rot_cnt_q <= '0;
      acc_q     <= '0;
    end else begin
      state_q   <= state_d;
      rot_cnt_q <= rot_cnt_d;
      acc_q     <= acc_d;
    end
  end

  // Result register, parts the sum pass from the output side.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_data_q <= acc_sum;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_data_q};

  // Ring of cells; cell i holds the count for value i+1.
  for (genvar g = 0; g < MAX_VALUE; g++) begin : g_cell
    adjseq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .idx_i   (IDX_W'(g)),
      .left_i  (counts[(g + MAX_VALUE - 1) % MAX_VALUE]),
      .right_i (counts[(g + 1) % MAX_VALUE]),
      .count_o (counts[g])
    );
  end

endmodule

// ----- tb/adjacent_step_sequence_count_core_test.sv -----
// ----------------------------------------------------------------------------
// adjacent_step_sequence_count_core_test
// Self-checking bench for the adjacent step sequence counter. Array
// positions go in as stream beats. A cycle-free model of the value counts
// predicts each way count. Every result beat is compared with the oldest
// prediction. Directed cases cover seeding, the edge values, fixed values
// above the limit and limit changes. Random arrays follow under several
// limit settings, with bursts of idle cycles on both stream sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adjacent_step_sequence_count_core_test;
  import adjseq_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = MAX_VALUE + 8;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;  // [7:0] fixed_value
  logic [0:0]  s_axis_tuser  = '0;  // [0] first_pos
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [29:0] way_count, [31:30] zero

  // Model of the block: one count per candidate value and the limit.
  logic [WAY_W-1:0] ways_model [MAX_VALUE];
  logic [7:0]       limit_model;
  logic [WAY_W-1:0] way_count_q [$];

  bit          calm;
  int unsigned mismatch_count;
  int unsigned n_items;
  int unsigned n_results;
  int unsigned n_cfg;

  adjacent_step_sequence_count_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Free-running clock.
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Apply one accepted position to the model and queue the way count it yields.
  task automatic advance_counts(input logic [7:0] fv, input logic fp, input logic lp);
    int unsigned      m;
    int unsigned      fvi;
    longint unsigned  s;
    longint unsigned  acc;
    logic [WAY_W-1:0] nxt [MAX_VALUE];
    m   = (limit_model > MAX_VALUE) ? MAX_VALUE : limit_model;
    fvi = fv;
    if (fp) begin
      for (int unsigned i = 0; i < MAX_VALUE; i++) ways_model[i] = '0;
      if (fvi == 0) begin
        for (int unsigned i = 0; i < m; i++) ways_model[i] = 1;
      end else if (fvi <= m) begin
        ways_model[fvi-1] = 1;
      end
    end else begin
      for (int unsigned i = 0; i < MAX_VALUE; i++) begin
        s = 0;
        if (i < m && (fvi == 0 || fvi == i + 1)) begin
          s = ways_model[i];
          if (i > 0) s += ways_model[i-1];
          if (i + 1 < m) s += ways_model[i+1];
          s = s % MODULUS;
        end
        nxt[i] = s[WAY_W-1:0];
      end
      ways_model = nxt;
    end
    if (lp) begin
      acc = 0;
      for (int unsigned i = 0; i < m; i++) acc = (acc + ways_model[i]) % MODULUS;
      way_count_q.push_back(acc[WAY_W-1:0]);
    end
  endtask

  // Random fixed value: mostly free or in range, sometimes anything at all.
  function automatic logic [7:0] pick_fixed(input int unsigned m);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'd0;
    if (r < 9 && m > 0) return 8'($urandom_range(1, m));
    return 8'($urandom_range(0, 255));
  endfunction

  // Send one position beat, with an optional idle burst ahead of it.
  task automatic send_pos(input logic [7:0] fv, input logic fp, input logic lp);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= fv;
    s_axis_tuser  <= fp;
    s_axis_tlast  <= lp;
    do @(posedge clk_i); while (!s_axis_tready);
    advance_counts(fv, fp, lp);
    n_items++;
  endtask

  // Hold the input side until every predicted result has come out.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (way_count_q.size() != 0);
  endtask

  // Drain, then let a position that yields no result finish as well.
  task automatic settle_block();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write max_value while the block is idle.
  task automatic write_limit(input logic [7:0] v);
    settle_block();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_model = v;
    n_cfg++;
  endtask

  // Steps before any seeding work on the cleared counts.
  task automatic test_unseeded_step();
    send_pos(8'd0, 1'b0, 1'b1);
    send_pos(8'd5, 1'b0, 1'b0);
    send_pos(8'd0, 1'b0, 1'b1);
  endtask

  // Seeding at the reset limit, the edge values and fixed values above it.
  task automatic test_seed_extremes();
    send_pos(8'd0, 1'b1, 1'b1);
    send_pos(8'd1, 1'b1, 1'b0);
    send_pos(8'd0, 1'b0, 1'b1);
    send_pos(8'd100, 1'b1, 1'b0);
    send_pos(8'd0, 1'b0, 1'b0);
    send_pos(8'd100, 1'b0, 1'b1);
    send_pos(8'd101, 1'b1, 1'b1);
    send_pos(8'd255, 1'b1, 1'b0);
    send_pos(8'd0, 1'b0, 1'b1);
    send_pos(8'd1, 1'b1, 1'b0);
    send_pos(8'd2, 1'b0, 1'b0);
    send_pos(8'd101, 1'b0, 1'b1);
  endtask

  // Limit of zero, a saturating limit, and a limit of one.
  task automatic test_limit_register();
    write_limit(8'd0);
    send_pos(8'd0, 1'b1, 1'b0);
    send_pos(8'd0, 1'b0, 1'b1);
    write_limit(8'd255);
    send_pos(8'd0, 1'b1, 1'b1);
    send_pos(8'd128, 1'b1, 1'b0);
    send_pos(8'd0, 1'b0, 1'b1);
    write_limit(8'd1);
    send_pos(8'd0, 1'b1, 1'b0);
    send_pos(8'd0, 1'b0, 1'b0);
    send_pos(8'd1, 1'b0, 1'b1);
  endtask

  // The limit shrinks and then grows in the middle of an array.
  task automatic test_limit_change_mid_array();
    write_limit(8'd100);
    send_pos(8'd0, 1'b1, 1'b0);
    write_limit(8'd10);
    send_pos(8'd0, 1'b0, 1'b1);
    write_limit(8'd5);
    send_pos(8'd3, 1'b1, 1'b0);
    write_limit(8'd128);
    send_pos(8'd0, 1'b0, 1'b0);
    send_pos(8'd0, 1'b0, 1'b1);
  endtask

  // Well-formed arrays with random content, some long, plus broken sequences.
  task automatic test_random_arrays(input int unsigned n_pos);
    int unsigned sent;
    int unsigned len;
    int unsigned m;
    bit          broken;
    logic        fp;
    logic        lp;
    sent = 0;
    m    = (limit_model > MAX_VALUE) ? MAX_VALUE : limit_model;
    while (sent < n_pos) begin
      if (!calm && $urandom_range(0, 19) == 0) drain_results();
      broken = ($urandom_range(0, 9) == 0);
      len    = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int unsigned p = 0; p < len; p++) begin
        fp = broken ? 1'($urandom_range(0, 1)) : (p == 0);
        lp = broken ? ($urandom_range(0, 3) == 0) : (p == len - 1);
        send_pos(pick_fixed(m), fp, lp);
      end
      sent += len;
    end
  endtask

  // Random arrays under a spread of limit settings.
  task automatic test_random_phases();
    write_limit(8'd128);
    test_random_arrays(200);
    write_limit(8'd3);
    test_random_arrays(200);
    write_limit(8'($urandom_range(4, 127)));
    test_random_arrays(200);
    write_limit(8'd255);
    test_random_arrays(200);
    write_limit(8'd1);
    test_random_arrays(200);
  endtask

  // Closing stretch with no idle cycles on either side.
  task automatic test_back_to_back();
    write_limit(8'd128);
    calm = 1'b1;
    test_random_arrays(130);
  endtask

  // Result-side ready with random stall bursts.
  initial begin
    @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Compare every result beat with the oldest predicted way count.
  always @(posedge clk_i) begin : check_results
    logic [WAY_W-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (way_count_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("[%0t] unexpected result beat: way_count %0d", $realtime,
                   m_axis_tdata[29:0]);
        end
      end else begin
        want = way_count_q.pop_front();
        if (m_axis_tdata[29:0] !== want || m_axis_tdata[31:30] !== 2'b00) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("[%0t] way_count mismatch: expected %0d, got %0d (pad %b)",
                     $realtime, want, m_axis_tdata[29:0], m_axis_tdata[31:30]);
          end
        end
      end
    end
  end

  // End the run if no beat moves on any channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("adjacent_step_sequence_count_core_test NOT OK");
    $finish;
  end

  // Test sequence.
  initial begin
    calm           = 1'b0;
    mismatch_count = 0;
    n_items        = 0;
    n_results      = 0;
    n_cfg          = 0;
    limit_model    = MAX_VAL_RESET;
    for (int unsigned i = 0; i < MAX_VALUE; i++) ways_model[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unseeded_step();
    test_seed_extremes();
    test_limit_register();
    test_limit_change_mid_array();
    test_random_phases();
    test_back_to_back();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d positions and checked %0d way counts over %0d limit writes.",
             n_items, n_results, n_cfg);
    $display("Limits 0, 1, 3, 100, 128 and 255 were covered; mismatches: %0d.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("adjacent_step_sequence_count_core_test OK");
    end else begin
      $display("adjacent_step_sequence_count_core_test NOT OK");
    end
    $finish;
  end

endmodule
